>>> hw/rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants of the content-type sniffer.
// ----------------------------------------------------------------------------
package cts_pkg;

   localparam int unsigned HdrDepth = 12;
   localparam int unsigned CntWidth = 4;
   localparam logic [CntWidth-1:0] LenMax = 4'd15;

   typedef logic [7:0] byte_type;
   typedef logic [CntWidth-1:0] cnt_type;
   typedef byte_type [HdrDepth-1:0] hdr_type;

   typedef enum logic [3:0] {
      TYPE_OCTET = 4'd0,
      TYPE_PNG   = 4'd1,
      TYPE_JPEG  = 4'd2,
      TYPE_GIF   = 4'd3,
      TYPE_MP4   = 4'd4,
      TYPE_AVI   = 4'd5,
      TYPE_MKV   = 4'd6,
      TYPE_PGM   = 4'd7,
      TYPE_PPM   = 4'd8,
      TYPE_PBM   = 4'd9,
      TYPE_PDF   = 4'd10,
      TYPE_TEXT  = 4'd11
   } type_code_type;

   // UTF-8 / NUL status of the buffer after the current byte
   typedef struct packed {
      logic bad;
      logic nul;
      logic pending;   // a multi-byte sequence is still open
   } utf8_stat_type;

   // Signatures, first byte in the top bits
   localparam logic [63:0] SigPng   = 64'h8950_4E47_0D0A_1A0A;
   localparam logic [23:0] SigJpeg  = 24'hFF_D8FF;
   localparam logic [47:0] SigGif87 = 48'h4749_4638_3761;
   localparam logic [47:0] SigGif89 = 48'h4749_4638_3961;
   localparam logic [31:0] SigFtyp  = 32'h6674_7970;
   localparam logic [31:0] SigRiff  = 32'h5249_4646;
   localparam logic [31:0] SigAvi   = 32'h4156_4920;
   localparam logic [31:0] SigEbml  = 32'h1A45_DFA3;
   localparam logic [39:0] SigPdf   = 40'h25_5044_462D;

   localparam byte_type ByteP     = 8'h50;
   localparam byte_type ByteNul   = 8'h00;
   localparam byte_type ByteSpace = 8'h20;
   localparam byte_type ByteTab   = 8'h09;
   localparam byte_type ByteCr    = 8'h0D;

endpackage

>>> hw/rtl/cts_if.sv
// ----------------------------------------------------------------------------
// cts_req_if / cts_rsp_if
// Valid/ready channels of the content-type sniffer.
// ----------------------------------------------------------------------------
interface cts_req_if;
   logic                valid;
   logic                ready;
   cts_pkg::byte_type   data_byte;
   logic                last_byte;
   logic                empty_buffer;

   modport source (output valid, data_byte, last_byte, empty_buffer, input ready);
   modport sink   (input valid, data_byte, last_byte, empty_buffer, output ready);
endinterface

interface cts_rsp_if;
   logic                    valid;
   logic                    ready;
   cts_pkg::type_code_type  type_code;
   logic                    video_flag;

   modport source (output valid, type_code, video_flag, input ready);
   modport sink   (input valid, type_code, video_flag, output ready);
endinterface

>>> hw/rtl/content_type_sniffer_unit.sv
// ----------------------------------------------------------------------------
// content_type_sniffer_unit
// Classifies a byte buffer by magic signature, else as UTF-8 text or octets.
// ----------------------------------------------------------------------------
//
//  channel   | dir | transaction                       | payload
//  ----------+-----+-----------------------------------+--------------------------
//  req_chan  | in  | one buffer byte, or an empty mark | data_byte, last_byte,
//            |     |                                   | empty_buffer
//  rsp_chan  | out | one type code per finished buffer | type_code, video_flag
//
//  One request transaction per cycle while rsp_chan takes results. A byte waits in
//  the input register; the buffer state and header store update, and the
//  classifier runs on the same cycle it leaves it. A result shows on rsp_chan
//  the cycle after that, from the result register.
//  Reset clears all control and buffer state; header bytes are never read
//  before the current buffer writes them, so they carry no reset.
//  A stalled rsp_chan only holds back a request that ends a buffer; other
//  bytes keep flowing behind a waiting result.
// ----------------------------------------------------------------------------
module content_type_sniffer_unit (
   input  logic        clock,
   input  logic        reset,
   cts_req_if.sink     req_chan,
   cts_rsp_if.source   rsp_chan
);
   import cts_pkg::*;

   // ---------------- input register ----------------
   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff;
   logic       in_last_ff;
   logic       in_empty_ff;
   logic       req_fire;
   logic       in_move;      // input register hands its transaction on

   // ---------------- buffer state ----------------
   hdr_type    hdr_ff, hdr_in;
   cnt_type    cnt_ff, cnt_in, cnt_nx;
   logic       take_byte;    // a real byte enters the buffer
   logic       end_buf;      // buffer finishes, result is produced

   utf8_stat_type  stat_in;
   type_code_type  code_nx;
   logic           video_nx;

   // ---------------- result register ----------------
   logic           rsp_valid_ff, rsp_valid_in;
   type_code_type  rsp_code_ff;
   logic           rsp_video_ff;

   // A buffer end needs the result register free (or draining this cycle);
   // anything else can always move on.
   assign in_move  = in_valid_ff &&
                     (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || in_move;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign in_valid_in = req_fire || (in_valid_ff && !in_move);

   // empty with no last is dropped; empty with last only classifies
   assign take_byte = in_move && !in_empty_ff;
   assign end_buf   = in_move && in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_chan.data_byte;
         in_last_ff  <= req_chan.last_byte;
         in_empty_ff <= req_chan.empty_buffer;
      end
   end

   // header store: byte n lands in slot n for the first slots only
   for (genvar k = 0; k < HdrDepth; k++) begin : g_hdr
      assign hdr_in[k] = (take_byte && cnt_ff == CntWidth'(k)) ? in_byte_ff : hdr_ff[k];
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

   // saturating length
   assign cnt_nx = (take_byte && cnt_ff != LenMax) ? cnt_ff + 4'd1 : cnt_ff;
   assign cnt_in = end_buf ? '0 : cnt_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   cts_utf8 u_utf8 (
      .clock     (clock),
      .reset     (reset),
      .take_byte (take_byte),
      .end_buf   (end_buf),
      .data_byte (in_byte_ff),
      .stat_in   (stat_in)
   );

   // classify on the state including the current byte
   cts_classify u_classify (
      .hdr        (hdr_in),
      .count      (cnt_nx),
      .stat       (stat_in),
      .type_code  (code_nx),
      .video_flag (video_nx)
   );

   assign rsp_valid_in = end_buf || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_buf) begin
         rsp_code_ff  <= code_nx;
         rsp_video_ff <= video_nx;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.type_code  = rsp_code_ff;
   assign rsp_chan.video_flag = rsp_video_ff;

   // ---------------- checks ----------------
   // a finished buffer never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      end_buf |-> !(rsp_valid_ff && !rsp_chan.ready))
      else $error("result overwritten while stalled");

   // video flag agrees with the code it travels with
   a_video_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_video_ff == (rsp_code_ff == TYPE_MP4 ||
                        rsp_code_ff == TYPE_AVI || rsp_code_ff == TYPE_MKV)))
      else $error("video_flag inconsistent with type_code");

   // each buffer starts from a zero length
   a_len_clear: assert property (@(posedge clock) disable iff (reset)
      end_buf |=> cnt_ff == '0)
      else $error("length not cleared at buffer end");

   // a byte that does not end a buffer is never held in the input register
   a_no_stall_mid: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_last_ff) |-> in_move)
      else $error("mid-buffer byte stalled");

endmodule

>>> hw/rtl/cts_utf8.sv
// ----------------------------------------------------------------------------
// cts_utf8
// Strict UTF-8 decoder state and NUL flag for the buffer in progress.
// ----------------------------------------------------------------------------
module cts_utf8 (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take_byte,
   input  logic                    end_buf,
   input  cts_pkg::byte_type       data_byte,
   output cts_pkg::utf8_stat_type  stat_in
);
   import cts_pkg::*;

   typedef enum logic [2:0] {
      RULE_ANY  = 3'd0,   // 80..BF
      RULE_A0   = 3'd1,   // A0..BF after E0
      RULE_9F   = 3'd2,   // 80..9F after ED
      RULE_90   = 3'd3,   // 90..BF after F0
      RULE_8F   = 3'd4    // 80..8F after F4
   } rule_type;

   logic [1:0] cont_ff, cont_in, cont_nx;
   rule_type   rule_ff, rule_in, rule_nx;
   logic       bad_ff, bad_in, bad_nx;
   logic       nul_ff, nul_in, nul_nx;
   byte_type   lo, hi;

   always_comb begin
      lo = 8'h80;
      hi = 8'hBF;
      unique case (rule_ff)
         RULE_A0: lo = 8'hA0;
         RULE_9F: hi = 8'h9F;
         RULE_90: lo = 8'h90;
         RULE_8F: hi = 8'h8F;
         default: ;
      endcase
   end

   always_comb begin
      cont_nx = cont_ff;
      rule_nx = rule_ff;
      bad_nx  = bad_ff;
      nul_nx  = nul_ff;
      if (take_byte) begin
         if (data_byte == ByteNul) nul_nx = 1'b1;
         if (!bad_ff) begin
            if (cont_ff != 2'd0) begin
               rule_nx = RULE_ANY;
               if (data_byte < lo || data_byte > hi) begin
                  bad_nx  = 1'b1;
                  cont_nx = 2'd0;
               end else begin
                  cont_nx = cont_ff - 2'd1;
               end
            end else if (data_byte < 8'h80) begin
               cont_nx = 2'd0;
            end else if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
               cont_nx = 2'd1;
            end else if (data_byte >= 8'hE0 && data_byte <= 8'hEF) begin
               cont_nx = 2'd2;
               rule_nx = (data_byte == 8'hE0) ? RULE_A0 :
                         (data_byte == 8'hED) ? RULE_9F : RULE_ANY;
            end else if (data_byte >= 8'hF0 && data_byte <= 8'hF4) begin
               cont_nx = 2'd3;
               rule_nx = (data_byte == 8'hF0) ? RULE_90 :
                         (data_byte == 8'hF4) ? RULE_8F : RULE_ANY;
            end else begin
               bad_nx = 1'b1;
            end
         end
      end
   end

   assign stat_in.bad     = bad_nx;
   assign stat_in.nul     = nul_nx;
   assign stat_in.pending = (cont_nx != 2'd0);

   // a finished buffer leaves the decoder clean for the next one
   assign cont_in = end_buf ? 2'd0     : cont_nx;
   assign rule_in = end_buf ? RULE_ANY : rule_nx;
   assign bad_in  = end_buf ? 1'b0     : bad_nx;
   assign nul_in  = end_buf ? 1'b0     : nul_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         cont_ff <= 2'd0;
         rule_ff <= RULE_ANY;
         bad_ff  <= 1'b0;
         nul_ff  <= 1'b0;
      end else begin
         cont_ff <= cont_in;
         rule_ff <= rule_in;
         bad_ff  <= bad_in;
         nul_ff  <= nul_in;
      end
   end

endmodule

>>> hw/rtl/cts_classify.sv
// ----------------------------------------------------------------------------
// cts_classify
// Signature match in priority order over the stored header bytes.
// ----------------------------------------------------------------------------
module cts_classify (
   input  cts_pkg::hdr_type        hdr,
   input  cts_pkg::cnt_type        count,
   input  cts_pkg::utf8_stat_type  stat,
   output cts_pkg::type_code_type  type_code,
   output logic                    video_flag
);
   import cts_pkg::*;

   logic m_png, m_jpeg, m_gif, m_mp4, m_avi, m_mkv, m_pdf, m_text;
   logic pnm_hdr, pnm_ws, m_pgm, m_ppm, m_pbm;

   assign m_png  = count >= 4'd8 &&
                   {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5], hdr[6], hdr[7]} == SigPng;
   assign m_jpeg = count >= 4'd3 && {hdr[0], hdr[1], hdr[2]} == SigJpeg;
   assign m_gif  = count >= 4'd6 &&
                   ({hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5]} == SigGif87 ||
                    {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4], hdr[5]} == SigGif89);
   assign m_mp4  = count >= 4'd12 && {hdr[4], hdr[5], hdr[6], hdr[7]} == SigFtyp;
   assign m_avi  = count >= 4'd12 && {hdr[0], hdr[1], hdr[2], hdr[3]} == SigRiff &&
                   {hdr[8], hdr[9], hdr[10], hdr[11]} == SigAvi;
   assign m_mkv  = count >= 4'd4 && {hdr[0], hdr[1], hdr[2], hdr[3]} == SigEbml;

   assign pnm_ws  = hdr[2] == ByteSpace || (hdr[2] >= ByteTab && hdr[2] <= ByteCr);
   assign pnm_hdr = count >= 4'd3 && hdr[0] == ByteP && pnm_ws;
   assign m_pgm   = pnm_hdr && (hdr[1] == 8'h32 || hdr[1] == 8'h35);
   assign m_ppm   = pnm_hdr && (hdr[1] == 8'h33 || hdr[1] == 8'h36);
   assign m_pbm   = pnm_hdr && (hdr[1] == 8'h31 || hdr[1] == 8'h34);

   assign m_pdf  = count >= 4'd5 && {hdr[0], hdr[1], hdr[2], hdr[3], hdr[4]} == SigPdf;
   assign m_text = count != 4'd0 && !stat.nul && !stat.bad && !stat.pending;

   always_comb begin
      priority if (m_png)  type_code = TYPE_PNG;
      else if (m_jpeg)     type_code = TYPE_JPEG;
      else if (m_gif)      type_code = TYPE_GIF;
      else if (m_mp4)      type_code = TYPE_MP4;
      else if (m_avi)      type_code = TYPE_AVI;
      else if (m_mkv)      type_code = TYPE_MKV;
      else if (m_pgm)      type_code = TYPE_PGM;
      else if (m_ppm)      type_code = TYPE_PPM;
      else if (m_pbm)      type_code = TYPE_PBM;
      else if (m_pdf)      type_code = TYPE_PDF;
      else if (m_text)     type_code = TYPE_TEXT;
      else                 type_code = TYPE_OCTET;
   end

   assign video_flag = type_code == TYPE_MP4 || type_code == TYPE_AVI ||
                       type_code == TYPE_MKV;

endmodule
